[hw/rtl/vns_pkg.sv]
// Shared constants and controller/datapath interface types for the Voronoi nearest-seed block.
package vns_pkg;

	localparam int MAX_SEEDS  = 256;
	localparam int COORD_BITS = 10;
	localparam int IDX_W      = $clog2(MAX_SEEDS);
	localparam int CNT_W      = 9;
	localparam int CHAN_W     = 8;
	localparam int COLOR_W    = 3 * CHAN_W;
	localparam int SQ_W       = 2 * COORD_BITS;
	localparam int DIST_W     = SQ_W + 1;
	localparam int ENTRY_W    = 2 * COORD_BITS + COLOR_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = CNT_W;

	localparam logic [CFG_IDX_W-1:0] REG_SEED_COUNT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_METRIC_MODE = 1'd1;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic METRIC_MANHATTAN = 1'b0;
	localparam logic METRIC_EUCLID_SQ = 1'b1;

	typedef struct packed {
		logic write;
		logic start;
		logic issue;
		logic load_out;
	} vns_cmd_t;

	typedef struct packed {
		logic last_issue;
		logic pipe_busy;
		logic out_free;
	} vns_sts_t;

endpackage

[hw/rtl/voronoi_nearest_seed.sv]
// Voronoi nearest-seed search: seed table load and per-pixel nearest-seed query.
// A load item is taken while the controller is idle and writes one seed RAM entry.
// A query scans n seeds, n = seed_count clamped to 1..256; the seed RAM's single read port
// supplies one seed per cycle, and no new item is taken until the result is loaded into the
// output register. One finished result waits there while the next item is taken.
// Reset (arst_n, async low): controller idle, seed_count = 1, metric Manhattan; seed RAM undefined.
module voronoi_nearest_seed (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [vns_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vns_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic [vns_pkg::IDX_W-1:0]           seed_index,
	input  logic [vns_pkg::COORD_BITS-1:0]      seed_x,
	input  logic [vns_pkg::COORD_BITS-1:0]      seed_y,
	input  logic [vns_pkg::CHAN_W-1:0]          seed_red,
	input  logic [vns_pkg::CHAN_W-1:0]          seed_green,
	input  logic [vns_pkg::CHAN_W-1:0]          seed_blue,
	input  logic [vns_pkg::COORD_BITS-1:0]      pixel_x,
	input  logic [vns_pkg::COORD_BITS-1:0]      pixel_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [vns_pkg::CHAN_W-1:0]          red,
	output logic [vns_pkg::CHAN_W-1:0]          green,
	output logic [vns_pkg::CHAN_W-1:0]          blue,
	output logic [vns_pkg::IDX_W-1:0]           nearest_index,
	output logic [vns_pkg::DIST_W-1:0]          nearest_distance
);

	vns_pkg::vns_cmd_t ctrl_cmd;
	vns_pkg::vns_sts_t dp_sts;

	vns_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action  (action),
		.sts     (dp_sts),
		.cmd     (ctrl_cmd)
	);

	vns_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (ctrl_cmd),
		.sts             (dp_sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.seed_index      (seed_index),
		.seed_x          (seed_x),
		.seed_y          (seed_y),
		.seed_red        (seed_red),
		.seed_green      (seed_green),
		.seed_blue       (seed_blue),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.nearest_index   (nearest_index),
		.nearest_distance(nearest_distance)
	);

	property p_query_blocks_input;
		@(posedge clk) disable iff (!arst_n)
			(in_valid && in_ready && action == vns_pkg::ACT_QUERY) |=> !in_ready;
	endproperty
	a_query_blocks_input: assert property (p_query_blocks_input)
		else $error("input taken again right after a query item");

	property p_load_out_after_drain;
		@(posedge clk) disable iff (!arst_n) ctrl_cmd.load_out |-> !dp_sts.pipe_busy;
	endproperty
	a_load_out_after_drain: assert property (p_load_out_after_drain)
		else $error("result loaded while the distance pipeline still holds a seed");

	property p_result_from_load;
		@(posedge clk) disable iff (!arst_n) $rose(out_valid) |-> $past(ctrl_cmd.load_out);
	endproperty
	a_result_from_load: assert property (p_result_from_load)
		else $error("result valid without a load of the output register");

endmodule

[hw/rtl/vns_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module vns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/vns_ctrl.sv]
// Controller state machine: load/query dispatch, seed scan sequencing and result handoff.
module vns_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  vns_pkg::vns_sts_t sts,
	output vns_pkg::vns_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_WAIT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (action == vns_pkg::ACT_QUERY) begin
						cmd.start = 1'b1;
						state_d   = ST_SCAN;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hw/rtl/vns_datapath.sv]
// Datapath: config registers, seed RAM, distance pipeline, running minimum and output register.
module vns_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vns_pkg::vns_cmd_t                   cmd,
	output vns_pkg::vns_sts_t                   sts,
	input  logic                                cfg_we,
	input  logic [vns_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vns_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [vns_pkg::IDX_W-1:0]           seed_index,
	input  logic [vns_pkg::COORD_BITS-1:0]      seed_x,
	input  logic [vns_pkg::COORD_BITS-1:0]      seed_y,
	input  logic [vns_pkg::CHAN_W-1:0]          seed_red,
	input  logic [vns_pkg::CHAN_W-1:0]          seed_green,
	input  logic [vns_pkg::CHAN_W-1:0]          seed_blue,
	input  logic [vns_pkg::COORD_BITS-1:0]      pixel_x,
	input  logic [vns_pkg::COORD_BITS-1:0]      pixel_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [vns_pkg::CHAN_W-1:0]          red,
	output logic [vns_pkg::CHAN_W-1:0]          green,
	output logic [vns_pkg::CHAN_W-1:0]          blue,
	output logic [vns_pkg::IDX_W-1:0]           nearest_index,
	output logic [vns_pkg::DIST_W-1:0]          nearest_distance
);

	logic [vns_pkg::CNT_W-1:0]      seed_count_q;
	logic                           metric_q;
	logic [vns_pkg::COORD_BITS-1:0] px_q, py_q;
	logic [vns_pkg::IDX_W-1:0]      addr_q, last_idx;
	logic [vns_pkg::ENTRY_W-1:0]    rdata;

	logic                           v_s1, first_s1;
	logic [vns_pkg::IDX_W-1:0]      idx_s1;
	logic [vns_pkg::COORD_BITS-1:0] sx_s1, sy_s1, dx_s1, dy_s1;
	logic [vns_pkg::COLOR_W-1:0]    col_s1;

	logic                           v_s2, first_s2;
	logic [vns_pkg::IDX_W-1:0]      idx_s2;
	logic [vns_pkg::COLOR_W-1:0]    col_s2;
	logic [vns_pkg::SQ_W-1:0]       pa_s2, pb_s2;
	logic [vns_pkg::DIST_W-1:0]     dist_s2;

	logic [vns_pkg::DIST_W-1:0]     best_d_q;
	logic [vns_pkg::IDX_W-1:0]      best_idx_q;
	logic [vns_pkg::COLOR_W-1:0]    best_col_q;
	logic                           out_valid_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_count_q <= vns_pkg::CNT_W'(1);
			metric_q     <= vns_pkg::METRIC_MANHATTAN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vns_pkg::REG_SEED_COUNT:  seed_count_q <= cfg_data;
				vns_pkg::REG_METRIC_MODE: metric_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// seed table: {x, y, red, green, blue}
	vns_ram #(
		.WIDTH(vns_pkg::ENTRY_W),
		.DEPTH(vns_pkg::MAX_SEEDS)
	) u_seed_ram (
		.clk  (clk),
		.we   (cmd.write),
		.waddr(seed_index),
		.wdata({seed_x, seed_y, seed_red, seed_green, seed_blue}),
		.raddr(addr_q),
		.rdata(rdata)
	);

	// zero count scans one seed, oversize count saturates to the table depth
	always_comb begin
		if (seed_count_q == '0) begin
			last_idx = '0;
		end else if (seed_count_q > vns_pkg::CNT_W'(vns_pkg::MAX_SEEDS)) begin
			last_idx = vns_pkg::IDX_W'(vns_pkg::MAX_SEEDS - 1);
		end else begin
			last_idx = vns_pkg::IDX_W'(seed_count_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			v_s2     <= 1'b0;
			first_s2 <= 1'b0;
		end else begin
			if (cmd.start) begin
				addr_q <= '0;
			end else if (cmd.issue) begin
				addr_q <= addr_q + 1'b1;
			end
			v_s1     <= cmd.issue;
			first_s1 <= cmd.issue && (addr_q == '0);
			v_s2     <= v_s1;
			first_s2 <= first_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
	end

	// stage 1: RAM data, absolute differences, squares or plain terms
	assign sx_s1  = rdata[vns_pkg::ENTRY_W-1 -: vns_pkg::COORD_BITS];
	assign sy_s1  = rdata[vns_pkg::COLOR_W +: vns_pkg::COORD_BITS];
	assign col_s1 = rdata[vns_pkg::COLOR_W-1:0];
	assign dx_s1  = (px_q >= sx_s1) ? (px_q - sx_s1) : (sx_s1 - px_q);
	assign dy_s1  = (py_q >= sy_s1) ? (py_q - sy_s1) : (sy_s1 - py_q);

	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
		col_s2 <= col_s1;
		if (metric_q == vns_pkg::METRIC_EUCLID_SQ) begin
			pa_s2 <= vns_pkg::SQ_W'(dx_s1) * vns_pkg::SQ_W'(dx_s1);
			pb_s2 <= vns_pkg::SQ_W'(dy_s1) * vns_pkg::SQ_W'(dy_s1);
		end else begin
			pa_s2 <= vns_pkg::SQ_W'(dx_s1);
			pb_s2 <= vns_pkg::SQ_W'(dy_s1);
		end
	end

	// stage 2: sum and strict-less running minimum (lowest index wins ties)
	assign dist_s2 = vns_pkg::DIST_W'(pa_s2) + vns_pkg::DIST_W'(pb_s2);

	always_ff @(posedge clk) begin
		if (v_s2 && (first_s2 || (dist_s2 < best_d_q))) begin
			best_d_q   <= dist_s2;
			best_idx_q <= idx_s2;
			best_col_q <= col_s2;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			red              <= best_col_q[2*vns_pkg::CHAN_W +: vns_pkg::CHAN_W];
			green            <= best_col_q[vns_pkg::CHAN_W +: vns_pkg::CHAN_W];
			blue             <= best_col_q[vns_pkg::CHAN_W-1:0];
			nearest_index    <= best_idx_q;
			nearest_distance <= best_d_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign sts.last_issue = (addr_q == last_idx);
	assign sts.pipe_busy  = v_s1 || v_s2;
	assign sts.out_free   = !out_valid_q || out_ready;

	property p_stage2_follows_stage1;
		@(posedge clk) disable iff (!arst_n) v_s2 |-> $past(v_s1);
	endproperty
	a_stage2_follows_stage1: assert property (p_stage2_follows_stage1)
		else $error("stage 2 valid without stage 1 the cycle before");

	property p_first_leads_scan;
		@(posedge clk) disable iff (!arst_n) (v_s2 && !$past(v_s2)) |-> first_s2;
	endproperty
	a_first_leads_scan: assert property (p_first_leads_scan)
		else $error("scan entered the compare stage without its first seed");

endmodule

[dv/voronoi_nearest_seed_tb.sv]
// Testbench for voronoi_nearest_seed: seed loads and pixel queries checked against a scan predictor.
module voronoi_nearest_seed_tb;
	import vns_pkg::*;

	localparam int unsigned COORD_MAX = (1 << COORD_BITS) - 1;
	localparam longint unsigned DIST_SAT = (64'd1 << DIST_W) - 1;
	localparam int unsigned SETTLE_CYCLES = MAX_SEEDS + 24;
	localparam int unsigned ITEM_TARGET = 1800;
	localparam int unsigned HOLD_AFTER = 400;
	localparam int unsigned HOLD_CYCLES = 3000;

	typedef struct {
		logic                  act;
		logic [IDX_W-1:0]      sidx;
		logic [COORD_BITS-1:0] sx;
		logic [COORD_BITS-1:0] sy;
		logic [CHAN_W-1:0]     sr;
		logic [CHAN_W-1:0]     sg;
		logic [CHAN_W-1:0]     sb;
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
	} pixel_job_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] distance;
	} seed_hit_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  action = ACT_LOAD;
	logic [IDX_W-1:0]      seed_index = '0;
	logic [COORD_BITS-1:0] seed_x = '0;
	logic [COORD_BITS-1:0] seed_y = '0;
	logic [CHAN_W-1:0]     seed_red = '0;
	logic [CHAN_W-1:0]     seed_green = '0;
	logic [CHAN_W-1:0]     seed_blue = '0;
	logic [COORD_BITS-1:0] pixel_x = '0;
	logic [COORD_BITS-1:0] pixel_y = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [CHAN_W-1:0]     red;
	logic [CHAN_W-1:0]     green;
	logic [CHAN_W-1:0]     blue;
	logic [IDX_W-1:0]      nearest_index;
	logic [DIST_W-1:0]     nearest_distance;

	voronoi_nearest_seed dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.action           (action),
		.seed_index       (seed_index),
		.seed_x           (seed_x),
		.seed_y           (seed_y),
		.seed_red         (seed_red),
		.seed_green       (seed_green),
		.seed_blue        (seed_blue),
		.pixel_x          (pixel_x),
		.pixel_y          (pixel_y),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.red              (red),
		.green            (green),
		.blue             (blue),
		.nearest_index    (nearest_index),
		.nearest_distance (nearest_distance)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [COORD_BITS-1:0] seed_pos_x [MAX_SEEDS];
	logic [COORD_BITS-1:0] seed_pos_y [MAX_SEEDS];
	logic [COLOR_W-1:0]    seed_rgb   [MAX_SEEDS];
	int unsigned           scan_count = 1;
	logic                  euclid_on = METRIC_MANHATTAN;

	pixel_job_t  job_q [$];
	seed_hit_t   hit_exp_q [$];
	int unsigned items_pushed = 0;
	int unsigned items_taken = 0;
	int unsigned results_seen = 0;
	int unsigned mismatch_count = 0;
	bit          in_taken = 1'b0;

	int unsigned send_gap = 0;
	int unsigned send_run = 0;
	bit          send_steady = 1'b0;
	int unsigned recv_stall = 0;
	int unsigned recv_run = 0;
	bit          recv_steady = 1'b0;
	bit          hold_done = 1'b0;

	function automatic int unsigned idle_len(bit steady);
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	function automatic seed_hit_t nearest_seed(logic [COORD_BITS-1:0] px,
			logic [COORD_BITS-1:0] py);
		int unsigned n, k, best_k;
		longint unsigned dx, dy, d, best_d;
		seed_hit_t hit;
		n = (scan_count == 0) ? 1 : scan_count;
		if (n > MAX_SEEDS)
			n = MAX_SEEDS;
		best_k = 0;
		best_d = 0;
		for (k = 0; k < n; k++) begin
			dx = (px >= seed_pos_x[k]) ? px - seed_pos_x[k] : seed_pos_x[k] - px;
			dy = (py >= seed_pos_y[k]) ? py - seed_pos_y[k] : seed_pos_y[k] - py;
			d = (euclid_on == METRIC_EUCLID_SQ) ? dx * dx + dy * dy : dx + dy;
			if (k == 0 || d < best_d) begin
				best_d = d;
				best_k = k;
			end
		end
		hit.red = seed_rgb[best_k][3*CHAN_W-1:2*CHAN_W];
		hit.green = seed_rgb[best_k][2*CHAN_W-1:CHAN_W];
		hit.blue = seed_rgb[best_k][CHAN_W-1:0];
		hit.idx = IDX_W'(best_k);
		hit.distance = DIST_W'((best_d > DIST_SAT) ? DIST_SAT : best_d);
		return hit;
	endfunction

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// monitor: predicts on accepted items, checks accepted results
	always @(posedge clk) begin
		seed_hit_t want;
		in_taken = arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (hit_exp_q.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected result expected none actual idx %0d dist %0d",
					$time, nearest_index, nearest_distance);
			end else begin
				want = hit_exp_q.pop_front();
				check_field("red", want.red, red);
				check_field("green", want.green, green);
				check_field("blue", want.blue, blue);
				check_field("nearest_index", want.idx, nearest_index);
				check_field("nearest_distance", want.distance, nearest_distance);
			end
		end
		if (in_taken) begin
			items_taken++;
			if (action == ACT_LOAD) begin
				seed_pos_x[seed_index] = seed_x;
				seed_pos_y[seed_index] = seed_y;
				seed_rgb[seed_index] = {seed_red, seed_green, seed_blue};
			end else begin
				hit_exp_q.push_back(nearest_seed(pixel_x, pixel_y));
			end
		end
	end

	// driver
	always @(negedge clk) begin
		pixel_job_t job;
		if (send_run == 0) begin
			send_run = $urandom_range(50, 400);
			send_steady = ($urandom_range(0, 3) == 0);
		end
		send_run--;
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (job_q.size() > 0) begin
				job = job_q.pop_front();
				in_valid <= 1'b1;
				action <= job.act;
				seed_index <= job.sidx;
				seed_x <= job.sx;
				seed_y <= job.sy;
				seed_red <= job.sr;
				seed_green <= job.sg;
				seed_blue <= job.sb;
				pixel_x <= job.px;
				pixel_y <= job.py;
				send_gap = idle_len(send_steady);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (recv_run == 0) begin
			recv_run = $urandom_range(50, 400);
			recv_steady = ($urandom_range(0, 3) == 0);
		end
		recv_run--;
		if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_done = 1'b1;
			recv_stall = HOLD_CYCLES;
		end
		if (recv_stall > 0) begin
			recv_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			recv_stall = idle_len(recv_steady);
		end
	end

	function automatic logic [COORD_BITS-1:0] pick_coord();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return COORD_BITS'($urandom_range(0, 7));
		if (r == 3)
			return COORD_BITS'($urandom_range(COORD_MAX - 7, COORD_MAX));
		return COORD_BITS'($urandom_range(0, COORD_MAX));
	endfunction

	task automatic push_load(int unsigned sidx, int unsigned sx, int unsigned sy,
			int unsigned sr, int unsigned sg, int unsigned sb);
		pixel_job_t job;
		job.act = ACT_LOAD;
		job.sidx = IDX_W'(sidx);
		job.sx = COORD_BITS'(sx);
		job.sy = COORD_BITS'(sy);
		job.sr = CHAN_W'(sr);
		job.sg = CHAN_W'(sg);
		job.sb = CHAN_W'(sb);
		job.px = COORD_BITS'($urandom);
		job.py = COORD_BITS'($urandom);
		job_q.push_back(job);
		items_pushed++;
	endtask

	task automatic push_query(int unsigned px, int unsigned py);
		pixel_job_t job;
		job.act = ACT_QUERY;
		job.sidx = IDX_W'($urandom);
		job.sx = COORD_BITS'($urandom);
		job.sy = COORD_BITS'($urandom);
		job.sr = CHAN_W'($urandom);
		job.sg = CHAN_W'($urandom);
		job.sb = CHAN_W'($urandom);
		job.px = COORD_BITS'(px);
		job.py = COORD_BITS'(py);
		job_q.push_back(job);
		items_pushed++;
	endtask

	task automatic push_random_load(int unsigned eff);
		int unsigned sidx;
		sidx = ($urandom_range(0, 9) < 6) ? $urandom_range(0, eff - 1)
			: $urandom_range(0, MAX_SEEDS - 1);
		push_load(sidx, pick_coord(), pick_coord(), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	task automatic wait_drained();
		while (items_taken != items_pushed || hit_exp_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] ridx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ridx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(int unsigned cnt, logic [CFG_DATA_W-1:0] metric_word);
		wait_drained();
		write_reg(REG_SEED_COUNT, CFG_DATA_W'(cnt));
		write_reg(REG_METRIC_MODE, metric_word);
		scan_count = cnt;
		euclid_on = metric_word[0];
	endtask

	initial begin
		int unsigned forced_count [5];
		int unsigned phase_no, cnt, eff, len, r, i;
		logic [CFG_DATA_W-1:0] metric_word;

		forced_count = '{256, 511, 1, 257, 2};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero seed count scans one seed; loads past the scan window are invisible
		set_config(0, {{(CFG_DATA_W-1){1'b0}}, METRIC_MANHATTAN});
		push_load(0, COORD_MAX, COORD_MAX, 8'hFF, 8'h00, 8'hAA);
		push_query(0, 0);
		push_query(COORD_MAX, COORD_MAX);
		push_query(0, COORD_MAX);
		push_load(1, 0, 0, 8'h00, 8'hFF, 8'h55);
		push_load(2, 512, 512, 8'h12, 8'h34, 8'h56);
		push_load(3, 512, 512, 8'h65, 8'h43, 8'h21);
		push_load(255, 10'h155, 10'h2AA, 8'h5A, 8'hA5, 8'hFF);
		push_query(0, 0);

		// euclid, upper data bits set on the metric write; ties go to the lower index
		set_config(4, {CFG_DATA_W{1'b1}});
		push_query(0, 0);
		push_query(COORD_MAX, COORD_MAX);
		push_query(512, 512);
		push_query(COORD_MAX, 0);
		push_query(0, COORD_MAX);
		push_query(256, 256);

		// largest distance, then fill the whole table
		set_config(1, {{(CFG_DATA_W-1){1'b0}}, METRIC_EUCLID_SQ});
		push_query(0, 0);
		push_query(COORD_MAX, COORD_MAX);
		for (i = 0; i < MAX_SEEDS; i++)
			push_load(i, pick_coord(), pick_coord(), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255));

		phase_no = 0;
		while (items_pushed < ITEM_TARGET) begin
			if (phase_no < 5) begin
				cnt = forced_count[phase_no];
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70)
					cnt = $urandom_range(1, 16);
				else if (r < 90)
					cnt = $urandom_range(17, 255);
				else if (r < 96)
					cnt = $urandom_range(256, (1 << CFG_DATA_W) - 1);
				else
					cnt = 0;
			end
			metric_word = CFG_DATA_W'($urandom);
			if (phase_no < 2)
				metric_word[0] = phase_no[0];
			set_config(cnt, metric_word);
			eff = (cnt == 0) ? 1 : ((cnt > MAX_SEEDS) ? MAX_SEEDS : cnt);
			len = (eff <= 16) ? 120 : ((eff < MAX_SEEDS) ? 40 : 16);
			for (i = 0; i < len; i++) begin
				if ($urandom_range(0, 1))
					push_query(pick_coord(), pick_coord());
				else
					push_random_load(eff);
			end
			phase_no++;
		end

		wait_drained();
		if (mismatch_count == 0 && hit_exp_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#6000000;
		$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/vns_pkg.sv
hw/rtl/vns_ram.sv
hw/rtl/vns_ctrl.sv
hw/rtl/vns_datapath.sv
hw/rtl/voronoi_nearest_seed.sv
dv/voronoi_nearest_seed_tb.sv
